>>> rtl/rcds_pkg.sv
// Shared types and constants for the radix conversion digit stack.
package rcds_pkg;

    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned RADIX_W    = 4;
    localparam int unsigned CHUNK_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_POP
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic pop;
    } dp_cmd_t;

    typedef struct packed {
        logic chunk_last;
        logic quot_zero;
        logic stack_one;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/rcds_if.sv
// Valid/ready channel interfaces for input values and output digits.
interface rcds_value_if #(
    parameter int unsigned VALUE_WIDTH = 31
) ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rcds_digit_if ();
    import rcds_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;

    modport source (output valid, output digit, output last_digit, input ready);
    modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

>>> rtl/radix_conversion_digit_stack.sv
// Top level of the radix conversion digit stack: radix register and block wiring.
//
// Each request on value_chan carries a non-negative integer. The block converts
// it to the base held in the radix register (values below 2 act as 2, values
// above 10 act as 10) and returns one request per digit on digit_chan, most
// significant digit first, with last_digit high on the final digit. A zero
// value gives the single digit 0.
//
// Conversion is repeated division. One division pass handles one eight-bit
// chunk of the value per cycle, and each pass pushes one remainder onto the
// digit stack. After the last pass the digits are popped from the stack and,
// while the receiver does not stall, follow one per cycle.
//
// value_chan is ready only while the block is idle, which it becomes as soon as
// the last digit has been read from the stack into the output register. When the
// receiver stalls, the current digit holds on digit_chan and popping waits. Reset
// empties the stack, clears out_valid and sets the radix to 10. The user writes
// the radix via cfg_we/cfg_wdata only while no conversion runs; nothing enforces it.
module radix_conversion_digit_stack #(
    parameter int unsigned VALUE_WIDTH = 31,
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rcds_pkg::RADIX_W-1:0] cfg_wdata,
    rcds_value_if.sink                   value_chan,
    rcds_digit_if.source                 digit_chan
);
    import rcds_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_eff;
    dp_cmd_t            cmd;
    dp_status_t         status;

    // The radix register takes any four-bit value; saturation happens on use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    rcds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (value_chan.valid),
        .in_ready (value_chan.ready),
        .cmd      (cmd),
        .status   (status)
    );

    rcds_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .radix      (radix_eff),
        .value      (value_chan.value),
        .out_valid  (digit_chan.valid),
        .out_ready  (digit_chan.ready),
        .digit      (digit_chan.digit),
        .last_digit (digit_chan.last_digit)
    );

endmodule

>>> rtl/rcds_datapath.sv
// Datapath: chunked long division by the radix, digit stack and output register.
module rcds_datapath #(
    parameter int unsigned VALUE_WIDTH = 31,
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcds_pkg::dp_cmd_t             cmd,
    output rcds_pkg::dp_status_t          status,
    input  logic [rcds_pkg::RADIX_W-1:0]  radix,
    input  logic [VALUE_WIDTH-1:0]        value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rcds_pkg::DIGIT_W-1:0]  digit,
    output logic                          last_digit
);
    import rcds_pkg::*;

    localparam int unsigned NCHUNK = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int unsigned WORK_W = NCHUNK * CHUNK_BITS;
    localparam int unsigned CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);

    logic [WORK_W-1:0]     work_reg;
    logic [WORK_W-1:0]     work_next;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [DIGIT_W-1:0]    rem_step;
    logic [CHUNK_BITS-1:0] quot_bits;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SP_W-1:0]       sp_reg;
    logic [SP_W-1:0]       sp_dec;
    logic [DIGIT_W-1:0]    digit_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic [DIGIT_W-1:0]    digit_store [STACK_DEPTH];

    // One chunk of restoring division, most significant bit first.
    always_comb
    begin
        logic [DIGIT_W:0]   trial;
        logic [DIGIT_W-1:0] r;
        r         = rem_reg;
        quot_bits = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            trial = {r, work_reg[WORK_W - CHUNK_BITS + i]};
            if (trial >= {1'b0, radix})
            begin
                r            = DIGIT_W'(trial - {1'b0, radix});
                quot_bits[i] = 1'b1;
            end
            else
            begin
                r = trial[DIGIT_W-1:0];
            end
        end
        rem_step = r;
    end

    // The top chunk is consumed and its quotient bits enter at the bottom, so after
    // all chunks the word holds the full quotient in place.
    generate
        if (NCHUNK == 1)
        begin : g_single
            assign work_next = quot_bits;
        end
        else
        begin : g_multi
            assign work_next = {work_reg[WORK_W-CHUNK_BITS-1:0], quot_bits};
        end
    endgenerate

    assign sp_dec = sp_reg - SP_W'(1);

    assign status.chunk_last = (cnt_reg == CNT_W'(NCHUNK - 1));
    assign status.quot_zero  = (work_next == '0);
    assign status.stack_one  = (sp_reg == SP_W'(1));
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= status.chunk_last ? '0 : cnt_reg + CNT_W'(1);
            end

            if (cmd.push && (sp_reg < SP_W'(STACK_DEPTH)))
            begin
                sp_reg <= sp_reg + SP_W'(1);
            end
            else if (cmd.pop)
            begin
                sp_reg <= sp_dec;
            end

            if (cmd.pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg <= WORK_W'(value);
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_next;
            rem_reg  <= status.chunk_last ? '0 : rem_step;
        end
    end

    // Digit stack with a registered read that feeds the output register directly.
    always_ff @(posedge clk)
    begin
        if (cmd.push && (sp_reg < SP_W'(STACK_DEPTH)))
        begin
            digit_store[sp_reg[ADDR_W-1:0]] <= rem_step;
        end
        if (cmd.pop)
        begin
            digit_reg <= digit_store[sp_dec[ADDR_W-1:0]];
            last_reg  <= status.stack_one;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign last_digit = last_reg;

endmodule

>>> rtl/rcds_ctrl.sv
// Controller: sequences loading, the division passes and popping of the stack.
module rcds_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output rcds_pkg::dp_cmd_t    cmd,
    input  rcds_pkg::dp_status_t status
);
    import rcds_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                // The final chunk of a pass yields the digit; a zero quotient ends it.
                if (status.chunk_last)
                begin
                    cmd.push = 1'b1;
                    if (status.quot_zero)
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                if (status.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (status.stack_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rcds_checker.sv
// Port-level assertions for the radix conversion digit stack, bound to the top level.
module rcds_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rcds_pkg::DIGIT_W-1:0] digit,
    input logic                         last_digit
);
    import rcds_pkg::*;

    // A stalled digit holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit) && $stable(last_digit))
        else $error("stalled digit changed or dropped");

    // A value is never followed directly by another one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted value");

    // Digits never reach the largest radix.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit <= DIGIT_MAX)
        else $error("digit out of range");

    // While digits of a conversion remain, no new value is taken.
    a_busy_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_digit |-> !in_ready)
        else $error("input ready while digits remain");

    // Taking a digit that is not the last brings the next one in the following cycle.
    a_digits_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_digit |=> out_valid)
        else $error("gap in the digit sequence");

endmodule

bind radix_conversion_digit_stack rcds_checker u_rcds_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (value_chan.valid),
    .in_ready   (value_chan.ready),
    .out_valid  (digit_chan.valid),
    .out_ready  (digit_chan.ready),
    .digit      (digit_chan.digit),
    .last_digit (digit_chan.last_digit)
);

>>> tb/rcds_digit_checker.sv
// Checker that predicts the digit sequence of every accepted value and compares it.
module rcds_digit_checker
    import rcds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [RADIX_W-1:0] cfg_wdata,
    rcds_value_if              value_mon,
    rcds_digit_if              digit_mon,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } digit_result_t;

    digit_result_t      pending_digits[$];
    logic [RADIX_W-1:0] radix_shadow;

    // Queue the digits of one value, most significant first.
    function automatic void stack_digits_of(input logic [30:0] number,
                                            input logic [RADIX_W-1:0] radix_raw);
        logic [DIGIT_W-1:0] digit_stack [0:31];
        logic [30:0]        rest;
        logic [30:0]        base;
        int                 depth;
        digit_result_t      entry;
        base = {27'd0, radix_raw};
        if (radix_raw < RADIX_MIN)
            base = {27'd0, RADIX_MIN};
        if (radix_raw > RADIX_MAX)
            base = {27'd0, RADIX_MAX};
        rest  = number;
        depth = 0;
        if (rest == 0)
        begin
            digit_stack[0] = '0;
            depth = 1;
        end
        else
        begin
            while (rest != 0)
            begin
                digit_stack[depth] = DIGIT_W'(rest % base);
                rest  = rest / base;
                depth = depth + 1;
            end
        end
        for (int i = depth - 1; i >= 0; i--)
        begin
            entry.digit      = digit_stack[i];
            entry.last_digit = (i == 0);
            pending_digits.push_back(entry);
        end
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        digit_result_t want;
        int            errs;
        if (!rst_n)
        begin
            radix_shadow <= RADIX_RESET;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
                radix_shadow <= cfg_wdata;
            if (value_mon.valid && value_mon.ready)
                stack_digits_of(value_mon.value, radix_shadow);
            if (digit_mon.valid && digit_mon.ready)
            begin
                if (pending_digits.size() == 0)
                begin
                    $error("digit %0d (last_digit %0d) arrived with nothing expected",
                           digit_mon.digit, digit_mon.last_digit);
                    errs = errs + 1;
                end
                else
                begin
                    want = pending_digits.pop_front();
                    if (digit_mon.digit !== want.digit)
                    begin
                        $error("digit: expected %0d, actual %0d", want.digit, digit_mon.digit);
                        errs = errs + 1;
                    end
                    if (digit_mon.last_digit !== want.last_digit)
                    begin
                        $error("last_digit: expected %0d, actual %0d",
                               want.last_digit, digit_mon.last_digit);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= pending_digits.size();
        end
    end

endmodule

>>> tb/tb.sv
// Top of the radix conversion testbench: clock, reset, stimulus and verdict.
module tb;
    import rcds_pkg::*;

    // The slowest correct run is roughly 425 values, each with up to 31 digits,
    // each digit possibly waiting out a long receiver stall. This limit is several
    // times that worst case.
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_VALUES = 50;
    localparam logic [30:0] VALUE_MASK   = 31'h7FFF_FFFF;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [RADIX_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic [30:0]        in_value = '0;
    logic               out_ready = 1'b0;

    // When steady is set, neither side inserts any idle cycles.
    logic               steady = 1'b0;
    int unsigned        stall_left = 0;
    int unsigned        cycle_count = 0;
    int                 fail_count;
    int                 pending;
    logic [RADIX_W-1:0] radix_now = RADIX_RESET;

    rcds_value_if #(.VALUE_WIDTH(31)) value_bus ();
    rcds_digit_if                     digit_bus ();

    assign value_bus.valid = in_valid;
    assign value_bus.value = in_value;
    assign digit_bus.ready = out_ready;

    radix_conversion_digit_stack #(
        .VALUE_WIDTH(31),
        .STACK_DEPTH(32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .value_chan(value_bus),
        .digit_chan(digit_bus)
    );

    rcds_digit_checker checker_inst (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .value_mon (value_bus),
        .digit_mon (digit_bus),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The run is ended here if the design hangs anywhere.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle lengths: most gaps are absent or short, and now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // The receiver drops ready for a random stretch about one cycle in four,
    // so stalls land on the first, middle and last digits alike.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 3) == 0)
        begin
            stall_left <= draw_gap();
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Random value shaped for the current radix. Besides fully random words, it
    // produces short words, tiny values and values right at a power of the radix,
    // where the digit count changes by one.
    function automatic logic [30:0] draw_value();
        logic [63:0] power;
        logic [63:0] base;
        int unsigned steps;
        base = {60'd0, radix_now};
        if (radix_now < RADIX_MIN)
            base = {60'd0, RADIX_MIN};
        if (radix_now > RADIX_MAX)
            base = {60'd0, RADIX_MAX};
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1: return 31'($urandom) >> $urandom_range(1, 30);
            2:
            begin
                power = 64'd1;
                steps = $urandom_range(0, 31);
                repeat (steps)
                begin
                    if (power * base <= {33'd0, VALUE_MASK})
                        power = power * base;
                end
                case ($urandom_range(0, 2))
                    0: return 31'(power);
                    1: return 31'(power - 64'd1);
                    default:
                    begin
                        if (power == {33'd0, VALUE_MASK})
                            return VALUE_MASK;
                        return 31'(power + 64'd1);
                    end
                endcase
            end
            default: return 31'($urandom_range(0, 20));
        endcase
    endfunction

    // Offer one request on the value channel and return at the edge where it is
    // taken. A back-to-back request keeps valid high and only changes the value.
    task automatic offer_value(input logic [30:0] number);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_value <= number;
        do
            @(posedge clk);
        while (!value_bus.ready);
    endtask

    // Lower valid and wait until every expected digit has come back. The first
    // edge lets the checker record the last accepted value.
    task automatic drain_digits();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // The radix is only written while the block sits idle.
    task automatic set_radix(input logic [RADIX_W-1:0] radix_code);
        drain_digits();
        cfg_we    <= 1'b1;
        cfg_wdata <= radix_code;
        radix_now  = radix_code;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first at the reset radix of ten: zero, the first digit
        // boundaries and the largest value.
        offer_value(31'd0);
        offer_value(31'd1);
        offer_value(31'd9);
        offer_value(31'd10);
        offer_value(VALUE_MASK);
        offer_value(31'd1_000_000_000);
        offer_value(31'd999_999_999);

        // Binary gives the longest digit strings, up to a full 31 digits.
        set_radix(RADIX_MIN);
        offer_value(31'd0);
        offer_value(31'd1);
        offer_value(VALUE_MASK);
        offer_value(31'h4000_0000);
        offer_value(31'h2AAA_AAAA);

        // Register codes below two act as binary.
        set_radix(4'd0);
        offer_value(31'd5);
        set_radix(4'd1);
        offer_value(31'd6);

        // Register codes above ten act as decimal.
        set_radix(4'd15);
        offer_value(31'd12345);
        set_radix(4'd11);
        offer_value(31'd10);
        offer_value(31'd2_147_483_646);

        // The largest digit of a base below ten, and an odd base.
        set_radix(4'd9);
        offer_value(31'd8);
        offer_value(31'd9);
        offer_value(31'd80);
        set_radix(4'd3);
        offer_value(VALUE_MASK);
        offer_value(31'd3);

        // Random part: each phase picks any register code, and about one phase in
        // four runs with no idle cycles on either side.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_radix(RADIX_W'($urandom_range(0, 15)));
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_VALUES; n++)
                offer_value(draw_value());
        end
        steady = 1'b0;

        drain_digits();
        // A stray digit after the last expected one would show up in this window.
        repeat (200) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
